FILE: rtl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants for the key/value table
// Operation and status codes, sequencer states and the cell command bundle.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // operation codes; the spare code behaves as a lookup
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_DUP    = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_ABSENT = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } kvt_state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic cmp;  // register the key compare
    logic ins;  // first free cell takes the new entry
    logic del;  // cells at and above the hit take their upper neighbour
  } kvt_cmd_t;

endpackage

FILE: rtl/kvt_if.sv
// ----------------------------------------------------------------------------
// kvt_if: request and result channels of the key/value table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface kvt_in_if #(
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] new_value;

  modport source (output valid, func, key, new_value, input ready);
  modport sink   (input valid, func, key, new_value, output ready);
endinterface

interface kvt_out_if #(
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF,
  parameter int CNT_BITS   = $clog2(kvt_pkg::CAPACITY_DEF + 1)
) ();
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [VALUE_BITS-1:0] read_value;
  logic [1:0]            status;
  logic [CNT_BITS-1:0]   count_now;
  logic                  is_empty;
  logic                  is_full;

  modport source (output valid, found, read_value, status, count_now, is_empty, is_full,
                  input ready);
  modport sink   (input valid, found, read_value, status, count_now, is_empty, is_full,
                  output ready);
endinterface

FILE: rtl/kvt_cell.sv
// ----------------------------------------------------------------------------
// kvt_cell: one entry of the table
// Holds key, value and a valid bit; compares against the broadcast key and
// takes its upper neighbour's entry when a delete closes the gap.
// ----------------------------------------------------------------------------
module kvt_cell #(
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kvt_pkg::kvt_cmd_t     cmd,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  prev_valid,  // lower neighbour holds an entry
  input  logic                  prev_hit,    // hit somewhere below
  input  logic [KEY_BITS-1:0]   nb_key,      // upper neighbour
  input  logic [VALUE_BITS-1:0] nb_value,
  input  logic                  nb_valid,
  output logic [KEY_BITS-1:0]   key_q,
  output logic [VALUE_BITS-1:0] value_q,
  output logic                  valid_q,
  output logic                  hit_out,
  output logic [VALUE_BITS-1:0] rd_value
);
  import kvt_pkg::*;

  logic [KEY_BITS-1:0]   key_r,   key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  valid_r, valid_nxt;
  logic                  match_r, match_nxt;
  logic                  take_new, take_nb;

  assign hit_out  = prev_hit | match_r;
  assign take_new = cmd.ins & ~valid_r & prev_valid;
  assign take_nb  = cmd.del & hit_out;

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    valid_nxt = valid_r;
    match_nxt = match_r;
    if (cmd.cmp) begin
      match_nxt = valid_r & (key_r == key);
    end
    if (take_new) begin
      key_nxt   = key;
      value_nxt = value;
      valid_nxt = 1'b1;
    end else if (take_nb) begin
      key_nxt   = nb_key;
      value_nxt = nb_value;
      valid_nxt = nb_valid;
      match_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign key_q    = key_r;
  assign value_q  = value_r;
  assign valid_q  = valid_r;
  assign rd_value = match_r ? value_r : '0;

endmodule

FILE: rtl/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table: associative key/value table built as a row of cells
// Result registered in the update state once the result register is free or
// draining. Each request passes transfer, compare and update through the cell
// row before the next is taken, also while an earlier result still waits.
// Reset: synchronous, active low; clears valid bits, count and missing value.
// Stored keys and values are not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_value_table #(
  parameter int CAPACITY   = kvt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kvt_in_if.sink                in_ch,
  kvt_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [VALUE_BITS-1:0] cfg_wdata
);
  import kvt_pkg::*;

  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(CAPACITY);

  // sequencer
  kvt_state_t state_r, state_nxt;
  kvt_cmd_t   cmd;
  logic       upd_go;

  // request held for the compare and update cycles
  logic [1:0]            op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] missing_r;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;

  // result register
  logic                  out_valid_r;
  logic                  found_r;
  logic [VALUE_BITS-1:0] rdval_r, rdval_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [CNT_BITS-1:0]   outcnt_r;

  // cell row wiring; the extra top slot is the empty entry beyond the end
  logic [KEY_BITS-1:0]   cell_key   [CAPACITY+1];
  logic [VALUE_BITS-1:0] cell_val   [CAPACITY+1];
  logic                  cell_valid [CAPACITY+1];
  logic                  hit_chain  [CAPACITY+1];
  logic [VALUE_BITS-1:0] cell_rd    [CAPACITY];
  logic [VALUE_BITS-1:0] rd_or;
  logic                  hit_any;
  logic                  is_ins, is_del, full_now;

  assign cell_key[CAPACITY]   = '0;
  assign cell_val[CAPACITY]   = '0;
  assign cell_valid[CAPACITY] = 1'b0;
  assign hit_chain[0]         = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic prev_v;
      if (gi == 0) begin : g_first
        assign prev_v = 1'b1;
      end else begin : g_rest
        assign prev_v = cell_valid[gi-1];
      end
      kvt_cell #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key        (key_r),
        .value      (val_r),
        .prev_valid (prev_v),
        .prev_hit   (hit_chain[gi]),
        .nb_key     (cell_key[gi+1]),
        .nb_value   (cell_val[gi+1]),
        .nb_valid   (cell_valid[gi+1]),
        .key_q      (cell_key[gi]),
        .value_q    (cell_val[gi]),
        .valid_q    (cell_valid[gi]),
        .hit_out    (hit_chain[gi+1]),
        .rd_value   (cell_rd[gi])
      );
    end
  endgenerate

  // keys are unique, so at most one cell drives a non-zero read value
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign hit_any  = hit_chain[CAPACITY];
  assign is_ins   = (op_r == FUNC_INSERT);
  assign is_del   = (op_r == FUNC_DELETE);
  assign full_now = (cnt_r == CNT_MAX);

  // update may only go ahead when the result register is free or draining
  assign upd_go = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.ins = upd_go & is_ins & ~hit_any;
        cmd.del = upd_go & is_del;
        if (upd_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // status, read value and new count of the current request
  always_comb begin
    cnt_nxt    = cnt_r;
    rdval_nxt  = missing_r;
    status_nxt = STAT_DONE;
    case (op_r)
      FUNC_INSERT: begin
        if (hit_any) begin
          status_nxt = STAT_DUP;
        end else if (full_now) begin
          status_nxt = STAT_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (hit_any) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          status_nxt = STAT_ABSENT;
        end
      end
      default: begin
        if (hit_any) begin
          rdval_nxt = rd_or;
        end else begin
          status_nxt = STAT_ABSENT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      missing_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) missing_r <= cfg_wdata;
      if (upd_go) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.func;
      key_r <= in_ch.key;
      val_r <= in_ch.new_value;
    end
    if (upd_go) begin
      found_r  <= hit_any;
      rdval_r  <= rdval_nxt;
      status_r <= status_nxt;
      outcnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = found_r;
  assign out_ch.read_value = rdval_r;
  assign out_ch.status     = status_r;
  assign out_ch.count_now  = outcnt_r;
  assign out_ch.is_empty   = (outcnt_r == '0);
  assign out_ch.is_full    = (outcnt_r == CNT_MAX);

endmodule
